>>> sv/smhr_pkg.sv
// ----------------------------------------------------------------------------
// smhr_pkg
// Shared sizes, codes and sequencer states for the bounded word stack.
// ----------------------------------------------------------------------------
package smhr_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  localparam int IN_TDATA_W  = ((3 + DW) + 7) / 8 * 8;
  localparam int OUT_TDATA_W = ((2 + DW) + 7) / 8 * 8;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] count_t;
  typedef logic [DW-1:0] word_t;

  typedef enum logic [2:0] {
    ACT_PUSH    = 3'd0,
    ACT_POP     = 3'd1,
    ACT_DISPLAY = 3'd2,
    ACT_MIDDLE  = 3'd3,
    ACT_REVERSE = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FEW   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_OUT,
    ST_RCHK,
    ST_RRI,
    ST_RRJ,
    ST_RWI,
    ST_RWJ,
    ST_RES
  } state_t;

endpackage

>>> sv/stack_middle_half_reverse_top.sv
// ----------------------------------------------------------------------------
// stack_middle_half_reverse_top
// Bounded stack of signed words with push, pop, display, middle and
// reverse of the bottom half, run by a small sequencer over one memory.
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (low bit up)          tlast
//  s_axis    in   action[2:0], value[34:3]           -
//  m_axis    out  status[1:0], data[33:2]            last
//
//  push and pop answer from ST_RES; display and middle read entries one
//  at a time through ST_RD and ST_OUT; reverse swaps each pair through
//  ST_RRI to ST_RWJ. s_axis_tready is high only while the sequencer is idle.
//  a held output word stalls the sequencer until m_axis_tready.
//  rst is synchronous and empties the stack; entry storage is not cleared.
// ----------------------------------------------------------------------------
module stack_middle_half_reverse_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [smhr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // action, value
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [smhr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // status, data
  output logic                               m_axis_tlast
);
  import smhr_pkg::*;

  word_t   mem [DEPTH];
  word_t   rdata;

  state_t  state, state_next;
  count_t  count, count_next;
  addr_t   idx, idx_next;
  addr_t   jdx, jdx_next;
  word_t   tmp, tmp_next;
  logic    disp, disp_next;
  status_t res_status, res_status_next;

  logic    out_valid, out_valid_next;
  status_t out_status, out_status_next;
  word_t   out_data, out_data_next;
  logic    out_last, out_last_next;

  logic    mem_we;
  addr_t   mem_waddr;
  word_t   mem_wdata;
  addr_t   mem_raddr;

  logic    out_free;
  action_t in_action;
  word_t   in_value;
  count_t  cm1;
  logic    is_last;

  assign in_action = action_t'(s_axis_tdata[2:0]);
  assign in_value  = s_axis_tdata[DW+2:3];
  assign cm1       = count - 1'b1;
  assign out_free  = !out_valid || m_axis_tready;
  assign is_last   = !disp || (idx == '0);

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - DW - 2){1'b0}}, out_data, out_status};
  assign m_axis_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    idx        <= idx_next;
    jdx        <= jdx_next;
    tmp        <= tmp_next;
    disp       <= disp_next;
    res_status <= res_status_next;
    out_status <= out_status_next;
    out_data   <= out_data_next;
    out_last   <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    jdx_next        = jdx;
    tmp_next        = tmp;
    disp_next       = disp;
    res_status_next = res_status;
    out_valid_next  = out_valid && !m_axis_tready;
    out_status_next = out_status;
    out_data_next   = out_data;
    out_last_next   = out_last;
    mem_we          = 1'b0;
    mem_waddr       = idx;
    mem_wdata       = rdata;
    mem_raddr       = idx;

    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (in_action)
            ACT_PUSH: begin
              state_next = ST_RES;
              if (count == CW'(DEPTH)) begin
                res_status_next = STAT_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = count[AW-1:0];
                mem_wdata       = in_value;
                count_next      = count + 1'b1;
                res_status_next = STAT_OK;
              end
            end
            ACT_POP: begin
              state_next = ST_RES;
              if (count == '0) begin
                res_status_next = STAT_EMPTY;
              end else begin
                count_next      = cm1;
                res_status_next = STAT_OK;
              end
            end
            ACT_DISPLAY, ACT_MIDDLE: begin
              if (count == '0) begin
                res_status_next = STAT_EMPTY;
                state_next      = ST_RES;
              end else begin
                disp_next  = (in_action == ACT_DISPLAY);
                idx_next   = (in_action == ACT_DISPLAY) ? cm1[AW-1:0] : AW'(cm1 >> 1);
                state_next = ST_RD;
              end
            end
            ACT_REVERSE: begin
              if (count < CW'(2)) begin
                res_status_next = STAT_FEW;
                state_next      = ST_RES;
              end else begin
                res_status_next = STAT_OK;
                idx_next        = '0;
                jdx_next        = AW'(cm1 >> 1);
                state_next      = ST_RCHK;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_RD: begin
        mem_raddr  = idx;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = STAT_OK;
          out_data_next   = rdata;
          out_last_next   = is_last;
          if (is_last) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx - 1'b1;
            state_next = ST_RD;
          end
        end
      end
      ST_RCHK: begin
        state_next = (idx < jdx) ? ST_RRI : ST_RES;
      end
      ST_RRI: begin
        mem_raddr  = idx;
        state_next = ST_RRJ;
      end
      ST_RRJ: begin
        mem_raddr  = jdx;
        tmp_next   = rdata;
        state_next = ST_RWI;
      end
      ST_RWI: begin
        mem_we     = 1'b1;
        mem_waddr  = idx;
        mem_wdata  = rdata;
        state_next = ST_RWJ;
      end
      ST_RWJ: begin
        mem_we     = 1'b1;
        mem_waddr  = jdx;
        mem_wdata  = tmp;
        idx_next   = idx + 1'b1;
        jdx_next   = jdx - 1'b1;
        state_next = ST_RCHK;
      end
      ST_RES: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_data_next   = '0;
          out_last_next   = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
